// File: hw/rtl/pesp_pkg.sv
// Shared types and constants of the polar envelope and phase split block.
package pesp_pkg;

  localparam int GAIN_W = 16;
  localparam int MODE_W = 2;
  localparam int REG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PHASE    = 2'd0,
    MODE_SCALED   = 2'd1,
    MODE_ENVELOPE = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE     = 2'd0,
    REG_MODE       = 2'd1,
    REG_DRIVE_GAIN = 2'd2,
    REG_PHASE_GAIN = 2'd3
  } reg_idx_t;

  // What an output lane shows after the gain multiply.
  typedef enum logic [1:0] {
    SEL_SCALED,
    SEL_ZERO,
    SEL_RAW
  } out_sel_t;

endpackage

// File: hw/rtl/pesp_if.sv
// Handshake interfaces for the sample input and result output channels.
interface pesp_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface pesp_result_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] drive_i;
  logic signed [SAMPLE_BITS-1:0] drive_q;
  logic signed [SAMPLE_BITS-1:0] phase_i;
  logic signed [SAMPLE_BITS-1:0] phase_q;
  modport source (output valid, output drive_i, output drive_q, output phase_i,
                  output phase_q, input ready);
  modport sink (input valid, input drive_i, input drive_q, input phase_i,
                input phase_q, output ready);
endinterface

// File: hw/rtl/polar_envelope_phase_split_core.sv
// Top level of the polar envelope and phase split block.
//
// One complex sample (sample_i, sample_q) enters on the smp channel per item and
// one result item (drive_i, drive_q, phase_i, phase_q) leaves on the res channel.
// Registers are written through cfg_we, cfg_index and cfg_data only while idle,
// which the user must keep to; the block itself does not enforce it. A sample
// passes the input, square and sum registers, the bit-per-stage square root and
// divider pipelines, the gain multiply register and the rounding and saturation
// register. One item is taken every cycle while the pipeline is not held.
// When res.ready is low and a result is waiting, the whole pipeline holds and
// smp.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads enable 1, mode 1, and both gains 4096
// (unity at twelve fraction bits).
module polar_envelope_phase_split_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pesp_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [pesp_pkg::GAIN_W-1:0]     cfg_data,
  pesp_sample_if.sink                     smp,
  pesp_result_if.source                   res
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int GW = pesp_pkg::GAIN_W;
  localparam int PW = S + GW + 1;
  localparam int D  = 2 * S + 3;
  localparam int MAGX = S + 2;
  localparam int QX   = 2 * S + 2;

  logic                 enable;
  pesp_pkg::mode_t      mode;
  logic [GW-1:0]        drive_gain;
  logic [GW-1:0]        phase_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      mode       <= pesp_pkg::MODE_SCALED;
      drive_gain <= GW'(4096);
      phase_gain <= GW'(4096);
    end else if (cfg_we) begin
      unique case (pesp_pkg::reg_idx_t'(cfg_index))
        pesp_pkg::REG_ENABLE:     enable     <= cfg_data[0];
        pesp_pkg::REG_MODE:       mode       <= pesp_pkg::mode_t'(cfg_data[1:0]);
        pesp_pkg::REG_DRIVE_GAIN: drive_gain <= cfg_data;
        pesp_pkg::REG_PHASE_GAIN: phase_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid;

  assign adv       = !out_valid || res.ready;
  assign smp.ready = adv;

  // Raw samples and valid bits travel alongside the arithmetic stages.
  logic [S-1:0] raw_i [D];
  logic [S-1:0] raw_q [D];
  logic         vld   [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < D; n++) vld[n] <= 1'b0;
    end else if (adv) begin
      vld[0] <= smp.valid;
      for (int n = 1; n < D; n++) vld[n] <= vld[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_i[0] <= smp.sample_i;
      raw_q[0] <= smp.sample_q;
      for (int n = 1; n < D; n++) begin
        raw_i[n] <= raw_i[n-1];
        raw_q[n] <= raw_q[n-1];
      end
    end
  end

  function automatic logic [S-1:0] mag_of(input logic [S-1:0] v);
    return v[S-1] ? (~v + S'(1)) : v;
  endfunction

  logic [2*S-1:0] sq_i;
  logic [2*S-1:0] sq_q;
  logic [2*S-1:0] sum_sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_i   <= {{S{1'b0}}, mag_of(raw_i[0])} * {{S{1'b0}}, mag_of(raw_i[0])};
      sq_q   <= {{S{1'b0}}, mag_of(raw_q[0])} * {{S{1'b0}}, mag_of(raw_q[0])};
      sum_sq <= sq_i + sq_q;
    end
  end

  logic [S-1:0] mag;

  pesp_isqrt #(.S(S)) u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .x    (sum_sq),
    .root (mag)
  );

  logic [S-1:0] unit_i;
  logic [S-1:0] unit_q;

  pesp_div #(.S(S)) u_div_i (
    .clk (clk),
    .adv (adv),
    .num (mag_of(raw_i[MAGX])),
    .den (mag),
    .quo (unit_i)
  );

  pesp_div #(.S(S)) u_div_q (
    .clk (clk),
    .adv (adv),
    .num (mag_of(raw_q[MAGX])),
    .den (mag),
    .quo (unit_q)
  );

  logic [S-1:0] mag_d [S];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_d[0] <= mag;
      for (int n = 1; n < S; n++) mag_d[n] <= mag_d[n-1];
    end
  end

  // Lanes: drive I, drive Q, phase I, phase Q.
  logic [S-1:0]        m_sel   [4];
  logic [GW-1:0]       g_sel   [4];
  logic                n_sel   [4];
  pesp_pkg::out_sel_t  s_sel   [4];

  always_comb begin
    logic [S-1:0] ri;
    logic [S-1:0] rq;
    logic [S-1:0] mg;
    ri = raw_i[QX];
    rq = raw_q[QX];
    mg = mag_d[S-1];
    m_sel[0] = mag_of(ri);
    m_sel[1] = mag_of(rq);
    n_sel[0] = ri[S-1];
    n_sel[1] = rq[S-1];
    g_sel[0] = drive_gain;
    g_sel[1] = drive_gain;
    g_sel[2] = phase_gain;
    g_sel[3] = phase_gain;
    s_sel[0] = enable ? pesp_pkg::SEL_SCALED : pesp_pkg::SEL_ZERO;
    s_sel[1] = s_sel[0];
    m_sel[2] = mag_of(ri);
    m_sel[3] = mag_of(rq);
    n_sel[2] = ri[S-1];
    n_sel[3] = rq[S-1];
    s_sel[2] = pesp_pkg::SEL_SCALED;
    if (!enable) begin
      s_sel[2] = pesp_pkg::SEL_RAW;
    end else begin
      unique case (mode)
        pesp_pkg::MODE_PHASE: begin
          m_sel[2] = unit_i;
          m_sel[3] = unit_q;
          if (mg == '0) s_sel[2] = pesp_pkg::SEL_ZERO;
        end
        pesp_pkg::MODE_SCALED: ;
        pesp_pkg::MODE_ENVELOPE: begin
          m_sel[2] = mg;
          m_sel[3] = mg;
          n_sel[2] = 1'b0;
          n_sel[3] = 1'b0;
        end
        pesp_pkg::MODE_NONE: s_sel[2] = pesp_pkg::SEL_ZERO;
        default: s_sel[2] = pesp_pkg::SEL_ZERO;
      endcase
    end
    s_sel[3] = s_sel[2];
  end

  logic [PW-1:0]       prod  [4];
  logic                p_neg [4];
  pesp_pkg::out_sel_t  p_sel [4];
  logic [S-1:0]        p_raw [4];
  logic                p_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= vld[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        prod[l]  <= PW'({{GW{1'b0}}, m_sel[l]} * {{S{1'b0}}, g_sel[l]});
        p_neg[l] <= n_sel[l];
        p_sel[l] <= s_sel[l];
      end
      p_raw[0] <= raw_i[QX];
      p_raw[1] <= raw_q[QX];
      p_raw[2] <= raw_i[QX];
      p_raw[3] <= raw_q[QX];
    end
  end

  logic [S-1:0] lane_next [4];

  always_comb begin
    logic [PW-1:0] rnd;
    logic [PW-1:0] lim;
    logic [S-1:0]  v;
    lim = PW'(1) << (S - 1);
    for (int l = 0; l < 4; l++) begin
      rnd = (prod[l] + (PW'(1) << (F - 1))) >> F;
      if (p_neg[l]) begin
        v = (rnd >= lim) ? lim[S-1:0] : (~rnd[S-1:0] + S'(1));
      end else begin
        v = (rnd >= lim) ? (lim[S-1:0] - S'(1)) : rnd[S-1:0];
      end
      unique case (p_sel[l])
        pesp_pkg::SEL_SCALED: lane_next[l] = v;
        pesp_pkg::SEL_RAW:    lane_next[l] = p_raw[l];
        pesp_pkg::SEL_ZERO:   lane_next[l] = '0;
        default:              lane_next[l] = '0;
      endcase
    end
  end

  logic [S-1:0] lane [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) lane[l] <= lane_next[l];
    end
  end

  assign res.valid   = out_valid;
  assign res.drive_i = lane[0];
  assign res.drive_q = lane[1];
  assign res.phase_i = lane[2];
  assign res.phase_q = lane[3];

endmodule

// File: hw/rtl/pesp_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module pesp_isqrt #(
  parameter int S = 16
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [2*S-1:0]   x,
  output logic [S-1:0]     root
);

  logic [S+1:0]   rem_r  [S];
  logic [S-1:0]   root_r [S];
  logic [2*S-1:0] x_r    [S];
  logic [S+1:0]   rem_next  [S];
  logic [S-1:0]   root_next [S];
  logic [2*S-1:0] x_next    [S];

  always_comb begin
    logic [S+1:0]   rem_in;
    logic [S-1:0]   root_in;
    logic [2*S-1:0] x_in;
    logic [S+1:0]   sh;
    logic [S+1:0]   trial;
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        x_in    = x;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        x_in    = x_r[k-1];
      end
      sh    = {rem_in[S-1:0], x_in[2*S-1:2*S-2]};
      trial = {root_in, 2'b01};
      if (sh >= trial) begin
        rem_next[k]  = sh - trial;
        root_next[k] = {root_in[S-2:0], 1'b1};
      end else begin
        rem_next[k]  = sh;
        root_next[k] = {root_in[S-2:0], 1'b0};
      end
      x_next[k] = {x_in[2*S-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < S; k++) begin
        rem_r[k]  <= rem_next[k];
        root_r[k] <= root_next[k];
        x_r[k]    <= x_next[k];
      end
    end
  end

  assign root = root_r[S-1];

endmodule

// File: hw/rtl/pesp_div.sv
// Pipelined restoring divider for the unit vector, one quotient bit per stage.
module pesp_div #(
  parameter int S = 16
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [S-1:0] num,
  input  logic [S-1:0] den,
  output logic [S-1:0] quo
);

  // The numerator is num shifted up by S-1; num never exceeds den.
  logic [S:0]   rem_r [S];
  logic [S-1:0] den_r [S];
  logic [S-1:0] quo_r [S];
  logic [S:0]   rem_next [S];
  logic [S-1:0] quo_next [S];

  always_comb begin
    logic [S:0]   r;
    logic [S-1:0] d;
    logic [S-1:0] q_in;
    for (int j = 0; j < S; j++) begin
      if (j == 0) begin
        r    = {1'b0, num};
        d    = den;
        q_in = '0;
      end else begin
        r    = {rem_r[j-1][S-1:0], 1'b0};
        d    = den_r[j-1];
        q_in = quo_r[j-1];
      end
      if (r >= {1'b0, d}) begin
        rem_next[j] = r - {1'b0, d};
        quo_next[j] = {q_in[S-2:0], 1'b1};
      end else begin
        rem_next[j] = r;
        quo_next[j] = {q_in[S-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < S; j++) begin
        rem_r[j] <= rem_next[j];
        quo_r[j] <= quo_next[j];
        den_r[j] <= (j == 0) ? den : den_r[j-1];
      end
    end
  end

  assign quo = quo_r[S-1];

endmodule

// File: test/tb_top.sv
// Testbench for the polar envelope and phase split core: directed and random samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 16;
  localparam int GF = 12;
  localparam int LAT = 2 * SB + 5;

  typedef struct packed {
    logic signed [SB-1:0] si;
    logic signed [SB-1:0] sq;
  } sample_t;

  typedef struct packed {
    logic signed [SB-1:0] drive_i;
    logic signed [SB-1:0] drive_q;
    logic signed [SB-1:0] phase_i;
    logic signed [SB-1:0] phase_q;
  } polar_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  pesp_pkg::reg_idx_t cfg_index = pesp_pkg::REG_ENABLE;
  logic [pesp_pkg::GAIN_W-1:0] cfg_data = '0;

  pesp_sample_if #(.SAMPLE_BITS(SB)) smp_if ();
  pesp_result_if #(.SAMPLE_BITS(SB)) res_if ();

  polar_envelope_phase_split_core #(.SAMPLE_BITS(SB), .GAIN_FRAC_BITS(GF)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .smp(smp_if.sink), .res(res_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file.
  logic              shd_enable;
  pesp_pkg::mode_t   shd_mode;
  logic [15:0]       shd_drive_gain;
  logic [15:0]       shd_phase_gain;

  sample_t pending_samples[$];
  polar_t  expected_polar[$];
  int      n_errors = 0;

  logic [15:0] corners [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};

  function automatic logic signed [SB-1:0] sat_scale(longint unsigned m, bit neg,
                                                     longint unsigned g);
    longint unsigned p;
    longint r;
    p = (m * g + (64'd1 << (GF - 1))) >> GF;
    r = neg ? -longint'(p) : longint'(p);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SB-1:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= x) root |= 64'd1 << b;
    end
    return root;
  endfunction

  function automatic polar_t predict_polar(sample_t s);
    polar_t r;
    longint si, sq;
    longint unsigned ai, aq, mag;
    si = s.si;
    sq = s.sq;
    r = '0;
    if (!shd_enable) begin
      r.phase_i = s.si;
      r.phase_q = s.sq;
      return r;
    end
    ai = si < 0 ? -si : si;
    aq = sq < 0 ? -sq : sq;
    mag = int_sqrt(ai * ai + aq * aq);
    r.drive_i = sat_scale(ai, si < 0, shd_drive_gain);
    r.drive_q = sat_scale(aq, sq < 0, shd_drive_gain);
    case (shd_mode)
      pesp_pkg::MODE_PHASE: if (mag != 0) begin
        r.phase_i = sat_scale((ai << (SB - 1)) / mag, si < 0, shd_phase_gain);
        r.phase_q = sat_scale((aq << (SB - 1)) / mag, sq < 0, shd_phase_gain);
      end
      pesp_pkg::MODE_SCALED: begin
        r.phase_i = sat_scale(ai, si < 0, shd_phase_gain);
        r.phase_q = sat_scale(aq, sq < 0, shd_phase_gain);
      end
      pesp_pkg::MODE_ENVELOPE: begin
        r.phase_i = sat_scale(mag, 1'b0, shd_phase_gain);
        r.phase_q = r.phase_i;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one item from the queue, with a random gap after each.
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      smp_if.valid <= 1'b0;
    end else if (smp_if.valid && !smp_if.ready) begin
    end else if (src_gap > 0) begin
      smp_if.valid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_samples.size() > 0) begin
      sample_t s;
      s = pending_samples.pop_front();
      expected_polar.push_back(predict_polar(s));
      smp_if.valid <= 1'b1;
      smp_if.sample_i <= s.si;
      smp_if.sample_q <= s.sq;
      src_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    end else begin
      smp_if.valid <= 1'b0;
    end
  end

  // Monitor with random back-pressure.
  int snk_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_polar.size() == 0) begin
          $error("unexpected result item");
          n_errors++;
        end else begin
          polar_t e;
          e = expected_polar.pop_front();
          if (res_if.drive_i !== e.drive_i) begin
            $error("drive_i expected %0d got %0d", e.drive_i, res_if.drive_i);
            n_errors++;
          end
          if (res_if.drive_q !== e.drive_q) begin
            $error("drive_q expected %0d got %0d", e.drive_q, res_if.drive_q);
            n_errors++;
          end
          if (res_if.phase_i !== e.phase_i) begin
            $error("phase_i expected %0d got %0d", e.phase_i, res_if.phase_i);
            n_errors++;
          end
          if (res_if.phase_q !== e.phase_q) begin
            $error("phase_q expected %0d got %0d", e.phase_q, res_if.phase_q);
            n_errors++;
          end
        end
        snk_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
      if (snk_gap > 0) begin
        res_if.ready <= 1'b0;
        snk_gap--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Waits until the queue is drained and every expected result has come.
  task automatic drain();
    while (pending_samples.size() > 0 || smp_if.valid || expected_polar.size() > 0)
      @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(pesp_pkg::reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pesp_pkg::REG_ENABLE:     shd_enable = val[0];
      pesp_pkg::REG_MODE:       shd_mode = pesp_pkg::mode_t'(val[1:0]);
      pesp_pkg::REG_DRIVE_GAIN: shd_drive_gain = val;
      default:                  shd_phase_gain = val;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return 16'd0;
      2: return 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    sample_t s;
    shd_enable = 1'b1;
    shd_mode = pesp_pkg::MODE_SCALED;
    shd_drive_gain = 16'd4096;
    shd_phase_gain = 16'd4096;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: corner samples in each mode.
    for (int m = 0; m < 4; m++) begin
      write_reg(pesp_pkg::REG_MODE, 16'(m));
      write_reg(pesp_pkg::REG_PHASE_GAIN, m[0] ? 16'hFFFF : 16'd4096);
      write_reg(pesp_pkg::REG_DRIVE_GAIN, m[1] ? 16'hFFFF : 16'd0);
      for (int k = 0; k < 5; k++) begin
        s.si = corners[k];
        s.sq = corners[5 - k];
        pending_samples.push_back(s);
      end
      drain();
    end
    write_reg(pesp_pkg::REG_ENABLE, 16'd0);
    s.si = 16'h8000; s.sq = 16'h7FFF;
    pending_samples.push_back(s);
    drain();
    // Random phases with varied register settings.
    for (int ph = 0; ph < 21; ph++) begin
      write_reg(pesp_pkg::REG_ENABLE, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'd1);
      write_reg(pesp_pkg::REG_MODE, 16'($urandom_range(0, 3)));
      write_reg(pesp_pkg::REG_DRIVE_GAIN, rand_gain());
      write_reg(pesp_pkg::REG_PHASE_GAIN, rand_gain());
      for (int k = 0; k < 50; k++) begin
        s.si = rand_sample();
        s.sq = rand_sample();
        pending_samples.push_back(s);
      end
      drain();
    end
    if (n_errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #(12ns * 400000);
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/pesp_pkg.sv
hw/rtl/pesp_if.sv
hw/rtl/pesp_isqrt.sv
hw/rtl/pesp_div.sv
hw/rtl/polar_envelope_phase_split_core.sv
test/tb_top.sv
